// File: rtl/core/slpd_pkg.sv
// ----------------------------------------------------------------------------
// slpd_pkg
// Types and constants shared by the slew-limited proportional drive block.
// ----------------------------------------------------------------------------
package slpd_pkg;

  // Field widths
  localparam int POS_W   = 21;
  localparam int ERR_W   = POS_W + 1;
  localparam int GAIN_W  = 16;
  localparam int VEL_W   = 15;
  localparam int DRV_W   = 16;
  localparam int RANGE_W = 16;
  localparam int TIME_W  = 16;
  localparam int TICK_W  = 8;
  localparam int CNT_W   = 17;
  localparam int DEM_W   = ERR_W + GAIN_W + 1;

  // Port widths
  localparam int IN_DATA_W  = 56;  // 50 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 21;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TARGET      = 3'd0,
    CFG_GAIN        = 3'd1,
    CFG_MAX_VEL     = 3'd2,
    CFG_ACCEL       = 3'd3,
    CFG_SETTLE_RNG  = 3'd4,
    CFG_SETTLE_TIME = 3'd5
  } cfg_idx_t;

  // Register reset values
  localparam logic signed [POS_W-1:0] TARGET_RST      = '0;
  localparam logic [GAIN_W-1:0]       GAIN_RST        = 16'd256;
  localparam logic [VEL_W-1:0]        MAX_VEL_RST     = 15'd25600;
  localparam logic [VEL_W-1:0]        ACCEL_RST       = 15'd512;
  localparam logic [RANGE_W-1:0]      SETTLE_RNG_RST  = 16'd10;
  localparam logic [TIME_W-1:0]       SETTLE_TIME_RST = 16'd200;

  // Configuration register set
  typedef struct packed {
    logic signed [POS_W-1:0] target;
    logic [GAIN_W-1:0]       gain;
    logic [VEL_W-1:0]        max_vel;
    logic [VEL_W-1:0]        accel;
    logic [RANGE_W-1:0]      settle_rng;
    logic [TIME_W-1:0]       settle_time;
  } cfg_t;

  // Per-side demand, already classified against the clamp
  typedef struct packed {
    logic signed [DRV_W-1:0] dem;   // valid when neither hi nor lo
    logic                    hi;    // demand above +max
    logic                    lo;    // demand below -max
  } side_dem_t;

  // Request passed from the demand stage to the control stage
  typedef struct packed {
    side_dem_t         l;
    side_dem_t         r;
    logic              out_band;  // either error outside the settle band
    logic [TICK_W-1:0] tick;
    logic              restart;
  } dem_req_t;

endpackage

// File: rtl/core/slew_limited_p_drive_with_settle_unit.sv
// ----------------------------------------------------------------------------
// slew_limited_p_drive_with_settle_unit
// Proportional drive with slew limit and settle detection, two encoder sides.
// ----------------------------------------------------------------------------
// Pipeline: a request passes the input register, the demand register and the
//   result register, in that order.
// Throughput: one request per cycle while out_tready allows; the control
//   stage's velocity/settle update is combinational, so requests may follow back to back.
// Reset (rst_n low, synchronous): velocities, settle counter and done clear,
//   pipeline empties, registers return to their documented defaults.
// ----------------------------------------------------------------------------
module slew_limited_p_drive_with_settle_unit
  import slpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [20:0] left_position, [41:21] right_position,
                                             // [49:42] tick_ms, [55:50] zero
  input  logic                   in_tuser,   // [0] restart
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // [15:0] left_drive, [31:16] right_drive
  output logic                   out_tuser,  // [0] done_res
  // Configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t     cfg_r;
  logic     dem_valid;
  logic     dem_ready;
  dem_req_t dem_req;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target      <= TARGET_RST;
      cfg_r.gain        <= GAIN_RST;
      cfg_r.max_vel     <= MAX_VEL_RST;
      cfg_r.accel       <= ACCEL_RST;
      cfg_r.settle_rng  <= SETTLE_RNG_RST;
      cfg_r.settle_time <= SETTLE_TIME_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_TARGET:      cfg_r.target      <= cfg_wdata[POS_W-1:0];
        CFG_GAIN:        cfg_r.gain        <= cfg_wdata[GAIN_W-1:0];
        CFG_MAX_VEL:     cfg_r.max_vel     <= cfg_wdata[VEL_W-1:0];
        CFG_ACCEL:       cfg_r.accel       <= cfg_wdata[VEL_W-1:0];
        CFG_SETTLE_RNG:  cfg_r.settle_rng  <= cfg_wdata[RANGE_W-1:0];
        CFG_SETTLE_TIME: cfg_r.settle_time <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  slpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .dn_valid  (dem_valid),
    .dn_ready  (dem_ready),
    .dn_req    (dem_req)
  );

  slpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (dem_valid),
    .up_ready   (dem_ready),
    .up_req     (dem_req),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/core/slpd_front.sv
// ----------------------------------------------------------------------------
// slpd_front
// Input register and demand stage: error, gain product, clamp and band checks.
// ----------------------------------------------------------------------------
module slpd_front
  import slpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // left_position, right_position, tick_ms
  input  logic                  in_tuser,   // restart
  input  cfg_t                  cfg,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output dem_req_t              dn_req
);

  // Stage 1: registered input request
  logic                     s1_vld_r;
  logic signed [POS_W-1:0]  s1_lpos_r;
  logic signed [POS_W-1:0]  s1_rpos_r;
  logic [TICK_W-1:0]        s1_tick_r;
  logic                     s1_restart_r;

  // Stage 2: registered demand request
  logic                     s2_vld_r;
  dem_req_t                 s2_req_r;
  dem_req_t                 s2_req_nxt;

  logic s1_rdy;
  logic s2_rdy;

  assign s2_rdy    = !s2_vld_r || dn_ready;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign dn_valid  = s2_vld_r;
  assign dn_req    = s2_req_r;

  // Error times gain, classified against the clamp
  function automatic side_dem_t side_demand(input logic signed [ERR_W-1:0] err,
                                            input logic [GAIN_W-1:0]       gain,
                                            input logic [VEL_W-1:0]        mx);
    logic signed [DEM_W-1:0] prod;
    logic signed [DEM_W-1:0] mx_s;
    side_dem_t               res;
    prod   = err * $signed({1'b0, gain});
    mx_s   = $signed({{(DEM_W-VEL_W){1'b0}}, mx});
    res.hi = prod > mx_s;
    res.lo = prod < -mx_s;
    res.dem = prod[DRV_W-1:0];
    return res;
  endfunction

  // Magnitude of an error above the band
  function automatic logic outside_band(input logic signed [ERR_W-1:0] err,
                                        input logic [RANGE_W-1:0]      rng);
    logic [ERR_W-1:0] mag;
    mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    return mag > {{(ERR_W-RANGE_W){1'b0}}, rng};
  endfunction

  // Demand stage logic
  always_comb begin
    logic signed [ERR_W-1:0] lerr;
    logic signed [ERR_W-1:0] rerr;
    lerr = ERR_W'(cfg.target) - ERR_W'(s1_lpos_r);
    rerr = ERR_W'(cfg.target) - ERR_W'(s1_rpos_r);
    s2_req_nxt.l        = side_demand(lerr, cfg.gain, cfg.max_vel);
    s2_req_nxt.r        = side_demand(rerr, cfg.gain, cfg.max_vel);
    s2_req_nxt.out_band = outside_band(lerr, cfg.settle_rng) ||
                          outside_band(rerr, cfg.settle_rng);
    s2_req_nxt.tick     = s1_tick_r;
    s2_req_nxt.restart  = s1_restart_r;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_tvalid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_tvalid && s1_rdy) begin
      s1_lpos_r    <= in_tdata[POS_W-1:0];
      s1_rpos_r    <= in_tdata[2*POS_W-1:POS_W];
      s1_tick_r    <= in_tdata[2*POS_W+TICK_W-1:2*POS_W];
      s1_restart_r <= in_tuser;
    end
    if (s1_vld_r && s2_rdy) begin
      s2_req_r <= s2_req_nxt;
    end
  end

endmodule

// File: rtl/core/slpd_slew.sv
// ----------------------------------------------------------------------------
// slpd_slew
// One side's velocity update: clamp to +/-max, else ramp by the accel step.
// ----------------------------------------------------------------------------
module slpd_slew
  import slpd_pkg::*;
(
  input  logic signed [DRV_W-1:0] vel_i,
  input  side_dem_t               dem_i,
  input  logic [VEL_W-1:0]        max_vel_i,
  input  logic [VEL_W-1:0]        accel_i,
  output logic signed [DRV_W-1:0] vel_o
);

  logic signed [DRV_W:0] up_sum;
  logic signed [DRV_W:0] dn_sum;
  logic signed [DRV_W-1:0] up_sat;
  logic signed [DRV_W-1:0] dn_sat;

  // Ramp up and down with 16-bit saturation
  assign up_sum = (DRV_W+1)'(vel_i) + $signed({2'b00, accel_i});
  assign dn_sum = (DRV_W+1)'(vel_i) - $signed({2'b00, accel_i});

  always_comb begin
    if (up_sum[DRV_W] != up_sum[DRV_W-1]) begin
      up_sat = up_sum[DRV_W] ? {1'b1, {(DRV_W-1){1'b0}}} : {1'b0, {(DRV_W-1){1'b1}}};
    end else begin
      up_sat = up_sum[DRV_W-1:0];
    end
    if (dn_sum[DRV_W] != dn_sum[DRV_W-1]) begin
      dn_sat = dn_sum[DRV_W] ? {1'b1, {(DRV_W-1){1'b0}}} : {1'b0, {(DRV_W-1){1'b1}}};
    end else begin
      dn_sat = dn_sum[DRV_W-1:0];
    end
  end

  // Select the new velocity
  always_comb begin
    if (dem_i.hi) begin
      vel_o = $signed({1'b0, max_vel_i});
    end else if (dem_i.lo) begin
      vel_o = -$signed({1'b0, max_vel_i});
    end else if (dem_i.dem > vel_i) begin
      vel_o = up_sat;
    end else if (dem_i.dem < vel_i) begin
      vel_o = dn_sat;
    end else begin
      vel_o = vel_i;
    end
  end

endmodule

// File: rtl/core/slpd_ctrl.sv
// ----------------------------------------------------------------------------
// slpd_ctrl
// Control stage: velocity state, settle counter, done latch, result register.
// ----------------------------------------------------------------------------
module slpd_ctrl
  import slpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  dem_req_t               up_req,
  input  cfg_t                   cfg,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,   // left_drive, right_drive
  output logic                   out_tuser    // done_res
);

  logic signed [DRV_W-1:0] lvel_r, lvel_nxt;
  logic signed [DRV_W-1:0] rvel_r, rvel_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    fin_r, fin_nxt;

  logic                    out_vld_r;
  logic signed [DRV_W-1:0] out_ldrv_r, out_ldrv_nxt;
  logic signed [DRV_W-1:0] out_rdrv_r, out_rdrv_nxt;
  logic                    out_done_r;

  logic                    acc;
  logic signed [DRV_W-1:0] lvel_eff, rvel_eff;
  logic [CNT_W-1:0]        cnt_eff;
  logic                    fin_eff;
  logic signed [DRV_W-1:0] lvel_slew, rvel_slew;
  logic [CNT_W:0]          cnt_sum;

  assign up_ready   = !out_vld_r || out_tready;
  assign acc        = up_valid && up_ready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_rdrv_r, out_ldrv_r};
  assign out_tuser  = out_done_r;

  // Restart clears the state before this request
  assign lvel_eff = up_req.restart ? '0 : lvel_r;
  assign rvel_eff = up_req.restart ? '0 : rvel_r;
  assign cnt_eff  = up_req.restart ? '0 : cnt_r;
  assign fin_eff  = up_req.restart ? 1'b0 : fin_r;

  slpd_slew u_slew_l (
    .vel_i     (lvel_eff),
    .dem_i     (up_req.l),
    .max_vel_i (cfg.max_vel),
    .accel_i   (cfg.accel),
    .vel_o     (lvel_slew)
  );

  slpd_slew u_slew_r (
    .vel_i     (rvel_eff),
    .dem_i     (up_req.r),
    .max_vel_i (cfg.max_vel),
    .accel_i   (cfg.accel),
    .vel_o     (rvel_slew)
  );

  assign cnt_sum = {1'b0, cnt_eff} + (CNT_W+1)'(up_req.tick);

  // Next state; frozen once done
  always_comb begin
    lvel_nxt = lvel_eff;
    rvel_nxt = rvel_eff;
    cnt_nxt  = cnt_eff;
    fin_nxt  = fin_eff;
    if (!fin_eff) begin
      lvel_nxt = lvel_slew;
      rvel_nxt = rvel_slew;
      if (up_req.out_band) begin
        cnt_nxt = '0;
      end else if (cnt_sum[CNT_W]) begin
        cnt_nxt = '1;
      end else begin
        cnt_nxt = cnt_sum[CNT_W-1:0];
      end
      fin_nxt = cnt_nxt > {{(CNT_W-TIME_W){1'b0}}, cfg.settle_time};
    end
    out_ldrv_nxt = fin_nxt ? '0 : lvel_nxt;
    out_rdrv_nxt = fin_nxt ? '0 : rvel_nxt;
  end

  // Control state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvel_r    <= '0;
      rvel_r    <= '0;
      cnt_r     <= '0;
      fin_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        lvel_r <= lvel_nxt;
        rvel_r <= rvel_nxt;
        cnt_r  <= cnt_nxt;
        fin_r  <= fin_nxt;
      end
      if (up_ready) out_vld_r <= up_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      out_ldrv_r <= out_ldrv_nxt;
      out_rdrv_r <= out_rdrv_nxt;
      out_done_r <= fin_nxt;
    end
  end

  // A done result always carries zero drives
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_done_r |-> out_ldrv_r == '0 && out_rdrv_r == '0)
    else $error("done result with nonzero drive");

  // Done stays latched until a restart request
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r && !(acc && up_req.restart) |=> fin_r)
    else $error("done latch dropped without restart");

  // Velocities freeze while done
  a_vel_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    acc && fin_r && !up_req.restart |=> $stable(lvel_r) && $stable(rvel_r))
    else $error("velocity changed while done");

  // Out-of-band error clears the settle counter
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !fin_eff && up_req.out_band |=> cnt_r == '0)
    else $error("settle counter not cleared");

endmodule

// File: dv/slew_limited_p_drive_with_settle_unit_tb.sv
// ----------------------------------------------------------------------------
// slew_limited_p_drive_with_settle_unit_tb
// Self-checking bench for the two-side slew-limited proportional drive. Each
// request is run through a local drive predictor when it is accepted, and
// every result is checked field by field against the oldest prediction.
// Covers clamp, ramp, band edge, settle/done latch, restart and register
// corners under random valid/ready gaps and long result stalls.
// ----------------------------------------------------------------------------
module slew_limited_p_drive_with_settle_unit_tb
  import slpd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CYCLE_LIMIT = 200000;
  localparam int     PIPE_LAT    = 3;
  localparam longint CNT_MAX     = (longint'(1) << CNT_W) - 1;

  // indexes past the register file; writes there must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef struct {
    logic signed [POS_W-1:0] lpos;
    logic signed [POS_W-1:0] rpos;
    logic [TICK_W-1:0]       tick;
    logic                    restart;
  } tick_req_t;

  typedef struct {
    logic signed [DRV_W-1:0] left;
    logic signed [DRV_W-1:0] right;
    logic                    done;
  } drive_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers
  longint tgt_q       = TARGET_RST;
  longint gain_q      = GAIN_RST;
  longint vmax_q      = MAX_VEL_RST;
  longint vstep_q     = ACCEL_RST;
  longint band_q      = SETTLE_RNG_RST;
  longint settle_ms_q = SETTLE_TIME_RST;

  // predictor copy of the control state
  longint lvel_q   = 0;
  longint rvel_q   = 0;
  longint settle_q = 0;
  logic   done_q   = 1'b0;

  drive_res_t drive_q[$];
  int         fail_cnt      = 0;
  int         cycle_cnt     = 0;
  int         src_idle_pct  = 0;
  int         sink_idle_pct = 0;
  int         rx_stall_len  = 0;
  int         rx_stall_trig = 0;
  int         rx_stall_seen = 0;
  int         rx_stall_left = 0;

  slew_limited_p_drive_with_settle_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drive predictor
  // --------------------------------------------------------------------------
  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // clamp on a large demand, otherwise step toward it (may overshoot)
  function automatic longint slew_toward(input longint vel, input longint err);
    longint demand;
    demand = err * gain_q;
    if (demand > vmax_q) return vmax_q;
    if (demand < -vmax_q) return -vmax_q;
    if (demand > vel) return clip16(vel + vstep_q);
    if (demand < vel) return clip16(vel - vstep_q);
    return vel;
  endfunction

  function automatic drive_res_t predict_drive(input tick_req_t t);
    drive_res_t r;
    longint     lerr;
    longint     rerr;
    if (t.restart) begin
      lvel_q   = 0;
      rvel_q   = 0;
      settle_q = 0;
      done_q   = 1'b0;
    end
    // frozen once done is latched
    if (!done_q) begin
      lerr   = tgt_q - longint'(t.lpos);
      rerr   = tgt_q - longint'(t.rpos);
      lvel_q = slew_toward(lvel_q, lerr);
      rvel_q = slew_toward(rvel_q, rerr);
      if ((lerr < 0 ? -lerr : lerr) > band_q || (rerr < 0 ? -rerr : rerr) > band_q) begin
        settle_q = 0;
      end else begin
        settle_q += t.tick;
        if (settle_q > CNT_MAX) settle_q = CNT_MAX;
      end
      if (settle_q > settle_ms_q) done_q = 1'b1;
    end
    r.left  = done_q ? '0 : DRV_W'(lvel_q);
    r.right = done_q ? '0 : DRV_W'(rvel_q);
    r.done  = done_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic tick_req_t mk_tick(input longint l, input longint r,
                                        input int tick, input bit restart);
    tick_req_t t;
    t.lpos    = POS_W'(l);
    t.rpos    = POS_W'(r);
    t.tick    = TICK_W'(tick);
    t.restart = restart;
    return t;
  endfunction

  // mostly near the target so the settle logic gets exercised
  function automatic tick_req_t rand_tick(input int spread);
    tick_req_t t;
    int        pick;
    int        w;
    longint    loff;
    longint    roff;
    pick = $urandom_range(99);
    w    = (band_q + 2 > 300) ? 300 : int'(band_q + 2);
    if (pick < 10) begin
      // right on the band edge
      loff = $urandom_range(1) ? band_q : -band_q;
      roff = $urandom_range(1) ? band_q : -band_q;
    end else if (pick < 55) begin
      loff = longint'($urandom_range(2 * w)) - w;
      roff = ($urandom_range(3) == 0) ? loff : longint'($urandom_range(2 * w)) - w;
    end else if (pick < 85) begin
      loff = longint'($urandom_range(2 * spread)) - spread;
      roff = longint'($urandom_range(2 * spread)) - spread;
    end else begin
      loff = $urandom;
      roff = $urandom;
    end
    t.lpos = POS_W'(tgt_q + loff);
    t.rpos = POS_W'(tgt_q + roff);
    case ($urandom_range(9))
      0:       t.tick = '0;
      1:       t.tick = '1;
      default: t.tick = TICK_W'($urandom_range(255));
    endcase
    t.restart = ($urandom_range(99) < 3);
    return t;
  endfunction

  task automatic send_tick(input tick_req_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - TICK_W - 2 * POS_W){1'b0}}, t.tick, t.rpos, t.lpos};
    in_tuser  <= t.restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    drive_q.push_back(predict_drive(t));
  endtask

  // stop offering, let every outstanding result come back, then a margin
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TARGET:      tgt_q       = longint'($signed(val[POS_W-1:0]));
      CFG_GAIN:        gain_q      = val[GAIN_W-1:0];
      CFG_MAX_VEL:     vmax_q      = val[VEL_W-1:0];
      CFG_ACCEL:       vstep_q     = val[VEL_W-1:0];
      CFG_SETTLE_RNG:  band_q      = val[RANGE_W-1:0];
      CFG_SETTLE_TIME: settle_ms_q = val[TIME_W-1:0];
      default: ;
    endcase
  endtask

  // junk above the register width now and then; it must be masked off
  function automatic logic [CFG_DATA_W-1:0] with_junk(input int val, input int w);
    logic [CFG_DATA_W-1:0] raw;
    raw = CFG_DATA_W'(val);
    if ($urandom_range(3) == 0) raw |= CFG_DATA_W'($urandom) << w;
    return raw;
  endfunction

  task automatic write_defaults(input int settle_ms);
    write_reg(CFG_TARGET, CFG_DATA_W'(TARGET_RST));
    write_reg(CFG_GAIN, CFG_DATA_W'(GAIN_RST));
    write_reg(CFG_MAX_VEL, CFG_DATA_W'(MAX_VEL_RST));
    write_reg(CFG_ACCEL, CFG_DATA_W'(ACCEL_RST));
    write_reg(CFG_SETTLE_RNG, CFG_DATA_W'(SETTLE_RNG_RST));
    write_reg(CFG_SETTLE_TIME, CFG_DATA_W'(settle_ms));
  endtask

  task automatic write_random_settings();
    int v;
    case ($urandom_range(7))
      0:       write_reg(CFG_TARGET, 21'h100000);
      1:       write_reg(CFG_TARGET, 21'h0FFFFF);
      2:       write_reg(CFG_TARGET, '0);
      default: write_reg(CFG_TARGET, CFG_DATA_W'($urandom));
    endcase
    case ($urandom_range(7))
      0:       v = 0;
      1:       v = 65535;
      2:       v = $urandom_range(65535);
      default: v = $urandom_range(1024);
    endcase
    write_reg(CFG_GAIN, with_junk(v, GAIN_W));
    case ($urandom_range(7))
      0:       v = 0;
      1:       v = 32767;
      2:       v = 25600;
      default: v = $urandom_range(25600);
    endcase
    write_reg(CFG_MAX_VEL, with_junk(v, VEL_W));
    case ($urandom_range(7))
      0:       v = 0;
      1:       v = 32767;
      default: v = $urandom_range(3000);
    endcase
    write_reg(CFG_ACCEL, with_junk(v, VEL_W));
    case ($urandom_range(7))
      0:       v = 0;
      1:       v = 65535;
      default: v = $urandom_range(40);
    endcase
    write_reg(CFG_SETTLE_RNG, with_junk(v, RANGE_W));
    case ($urandom_range(7))
      0:       v = 0;
      1:       v = $urandom_range(65535);
      default: v = $urandom_range(3000);
    endcase
    write_reg(CFG_SETTLE_TIME, with_junk(v, TIME_W));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready, optional long hold-off, field checks
  // --------------------------------------------------------------------------
  task automatic check_drive();
    drive_res_t want;
    if (drive_q.size() == 0) begin
      $error("result with no request outstanding: data %h done %b", out_tdata, out_tuser);
      fail_cnt++;
      return;
    end
    want = drive_q.pop_front();
    if (out_tdata[DRV_W-1:0] !== want.left) begin
      $error("left_drive mismatch: expected %0d, got %0d",
             want.left, $signed(out_tdata[DRV_W-1:0]));
      fail_cnt++;
    end
    if (out_tdata[2*DRV_W-1:DRV_W] !== want.right) begin
      $error("right_drive mismatch: expected %0d, got %0d",
             want.right, $signed(out_tdata[2*DRV_W-1:DRV_W]));
      fail_cnt++;
    end
    if (out_tuser !== want.done) begin
      $error("done_res mismatch: expected %0d, got %0d", want.done, out_tuser);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_drive();
    if (rx_stall_trig != rx_stall_seen) begin
      rx_stall_seen = rx_stall_trig;
      rx_stall_left = rx_stall_len;
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset register values: clamp, ramp, band edge, finish, done hold, restart
  task automatic test_directed_defaults();
    send_tick(mk_tick(-1048576, -1048576, 0, 0));
    send_tick(mk_tick(1048575, 1048575, 255, 0));
    send_tick(mk_tick(-100, 100, 1, 0));     // demand equal to the clamp
    send_tick(mk_tick(50, -50, 1, 0));
    send_tick(mk_tick(10, -10, 100, 0));     // error magnitude equals the band
    send_tick(mk_tick(11, 0, 50, 0));        // one past the band
    send_tick(mk_tick(-10, 10, 150, 0));
    send_tick(mk_tick(0, 0, 50, 0));         // count equals settle time
    send_tick(mk_tick(0, 0, 1, 0));          // finishes here
    send_tick(mk_tick(1048575, -1048576, 255, 0));
    send_tick(mk_tick(0, 0, 0, 1));
    send_tick(mk_tick(3, -3, 255, 1));       // restart and finish in one request
    send_tick(mk_tick(5, 5, 0, 1));
    send_tick(mk_tick(-1, 1, 0, 0));
    send_tick(mk_tick(-1048576, 1048575, 128, 0));
    send_tick(mk_tick(0, 0, 255, 0));
  endtask

  // register extremes, masked upper bits, writes past the last index
  task automatic test_register_corners();
    wait_idle();
    write_reg(CFG_TARGET, 21'h0FFFFF);
    write_reg(CFG_GAIN, 21'd1);
    write_reg(CFG_MAX_VEL, 21'd32767);
    write_reg(CFG_ACCEL, 21'd32767);          // drives velocity saturation
    write_reg(CFG_SETTLE_RNG, 21'd0);
    write_reg(CFG_SETTLE_TIME, 21'd0);
    repeat (15) send_tick(rand_tick(40000));

    wait_idle();
    write_reg(CFG_TARGET, 21'h100000);
    write_reg(CFG_GAIN, 21'd65535);
    write_reg(CFG_MAX_VEL, 21'd0);
    write_reg(CFG_ACCEL, 21'd0);
    write_reg(CFG_SETTLE_RNG, 21'd65535);
    write_reg(CFG_SETTLE_TIME, 21'd65535);
    repeat (15) send_tick(rand_tick(4000));

    wait_idle();
    write_reg(CFG_TARGET, 21'h000000);
    write_reg(CFG_GAIN, 21'h1F0180);
    write_reg(CFG_MAX_VEL, 21'h1F6400);
    write_reg(CFG_ACCEL, 21'h1F8200);
    write_reg(CFG_SETTLE_RNG, 21'h1F0014);
    write_reg(CFG_SETTLE_TIME, 21'h1F012C);
    write_reg(CFG_SPARE_6, 21'h1FFFFF);
    write_reg(CFG_SPARE_7, 21'h1FFFFF);
    repeat (15) send_tick(rand_tick(400));
  endtask

  task automatic test_random_settings(input int n_settings, input int n_ticks);
    repeat (n_settings) begin
      wait_idle();
      write_random_settings();
      repeat (n_ticks) send_tick(rand_tick(($urandom_range(1)) ? 200 : 4000));
    end
  endtask

  // longest settle time: in band with full ticks until done latches
  task automatic test_long_settle();
    wait_idle();
    write_defaults(65535);
    send_tick(mk_tick(tgt_q, tgt_q, 255, 1));
    repeat (261) begin
      send_tick(mk_tick(tgt_q + $urandom_range(20) - 10, tgt_q + $urandom_range(20) - 10,
                        255, 0));
    end
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    write_defaults(SETTLE_TIME_RST);
    rx_stall_len = 150;
    rx_stall_trig++;
    repeat (50) send_tick(rand_tick(2000));
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_pause_drain();
    repeat (10) send_tick(rand_tick(300));
    wait_idle();
    repeat (10) send_tick(rand_tick(300));
  endtask

  initial begin
    src_idle_pct  = 14;
    sink_idle_pct = 57;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_defaults();
    test_register_corners();
    test_random_settings(4, 55);

    src_idle_pct  = 57;
    sink_idle_pct = 14;
    test_long_settle();
    test_random_settings(4, 55);
    test_backpressure();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_settings(4, 55);
    test_pause_drain();

    wait_idle();
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
